### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the sequence packer sources.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Types, register indexes and code tables of the sequence code packer.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int unsigned WORD_BITS    = 32;
   localparam int unsigned SEQ_LEN_BITS = 24;
   localparam int unsigned CODE_BITS    = 5;
   localparam int unsigned SLOT_BITS    = 4;

   localparam logic [WORD_BITS-1:0] SENTINEL_WORD = 32'h0000_0001;

   // register indexes on the csr port
   typedef enum logic {
      REG_ALPHABET = 1'b0,
      REG_COMPACT  = 1'b1
   } csr_index_type;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_GAP     = 8'h2D;
   localparam logic [7:0] CHAR_STOP    = 8'h2A;

   // nucleotide codes
   localparam logic [2:0] NUC_NONE = 3'b000;
   localparam logic [2:0] NUC_U    = 3'b001;
   localparam logic [2:0] NUC_C    = 3'b010;
   localparam logic [2:0] NUC_T    = 3'b011;
   localparam logic [2:0] NUC_A    = 3'b100;
   localparam logic [2:0] NUC_G    = 3'b101;
   localparam logic [2:0] NUC_X    = 3'b110;
   localparam logic [2:0] NUC_N    = 3'b111;

   localparam logic [CODE_BITS-1:0] PROT_GAP  = 5'd29;
   localparam logic [CODE_BITS-1:0] PROT_STOP = 5'd30;

   // indexed by letter, A first
   localparam logic [2:0] NUC_LETTER [26] = '{
      NUC_A, NUC_NONE, NUC_C, NUC_NONE, NUC_NONE, NUC_NONE, NUC_G, NUC_NONE,
      NUC_NONE, NUC_NONE, NUC_NONE, NUC_NONE, NUC_NONE, NUC_N, NUC_NONE, NUC_NONE,
      NUC_NONE, NUC_NONE, NUC_NONE, NUC_T, NUC_U, NUC_NONE, NUC_NONE, NUC_X,
      NUC_NONE, NUC_NONE
   };

   localparam logic [CODE_BITS-1:0] PROT_LETTER [26] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd0, 5'd10, 5'd11,
      5'd12, 5'd13, 5'd0, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20,
      5'd21, 5'd31, 5'd22, 5'd23
   };

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_sequence;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]    packed_word;
      logic                    word_valid;
      logic                    last_word;
      logic [SEQ_LEN_BITS-1:0] seq_length;
   } rsp_payload_type;

   function automatic logic [CODE_BITS-1:0] map_code(input logic [7:0] c,
                                                     input logic       protein);
      logic [7:0]           u;
      logic [4:0]           idx;
      logic [CODE_BITS-1:0] code;
      u    = c;
      idx  = '0;
      code = '0;
      if (c inside {[8'h61:8'h7A]}) begin
         u = c - 8'h20;
      end
      if (u inside {[8'h41:8'h5A]}) begin
         idx  = 5'(u - 8'h41);
         code = protein ? PROT_LETTER[idx] : {2'b00, NUC_LETTER[idx]};
      end else if (protein && u == CHAR_GAP) begin
         code = PROT_GAP;
      end else if (protein && u == CHAR_STOP) begin
         code = PROT_STOP;
      end
      return code;
   endfunction

   function automatic logic [3:0] slot_width(input logic protein, input logic compact);
      if (compact) begin
         return protein ? 4'd5 : 4'd3;
      end
      return protein ? 4'd8 : 4'd4;
   endfunction

   function automatic logic [SLOT_BITS-1:0] slot_capacity(input logic protein,
                                                          input logic compact);
      if (compact) begin
         return protein ? 4'd6 : 4'd10;
      end
      return protein ? 4'd4 : 4'd8;
   endfunction

endpackage

### rtl/core/sequence_code_packer_unit.sv
// ----------------------------------------------------------------------------
// sequence_code_packer_unit
// Packs sequence bytes into 32-bit code words, first code in the high slot.
// ----------------------------------------------------------------------------
// Bytes arrive on the req_ channel, one per transaction; newlines are dropped.
// Each other byte is mapped to a nucleotide or protein code and shifted into
// the word being built. A full word, or any byte flagged end_of_sequence,
// yields one rsp_ transaction carrying the word and the running length.
// The result is registered on rsp_, or held in the skid entry while the receiver stalls.
// Throughput: one byte per cycle while req_stall is low, set by the single code-map
// and shift stage in front of the result register.
// The result register is backed by one skid entry, so a byte is still taken
// while a result waits; req_stall rises only once the skid entry is occupied
// and falls the cycle after the receiver takes a result.
// The csr_ port holds alphabet (address 0) and compact_mode (address 4);
// write them only while no transaction is in flight.
// Reset (synchronous) empties both result entries, returns the word to the
// sentinel value with no codes and clears the length counter and registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequence_code_packer_unit #(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  scp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output scp_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int unsigned WB = scp_pkg::WORD_BITS;
   localparam int unsigned SB = scp_pkg::SLOT_BITS;

   logic alphabet_ff, alphabet_in;
   logic compact_ff, compact_in;

   logic [WB-1:0]          acc_ff, acc_in;
   logic [SB-1:0]          slot_count_ff, slot_count_in;
   logic [LENGTH_BITS-1:0] length_counter_ff, length_counter_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   scp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   scp_pkg::rsp_payload_type skid_data_ff, skid_data_in;

   // ---------------- csr port
   logic                   csr_write;
   scp_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = scp_pkg::csr_index_type'(csr_paddr[2]);

   always_comb begin
      alphabet_in = alphabet_ff;
      compact_in  = compact_ff;
      if (csr_write) begin
         case (csr_index)
            scp_pkg::REG_ALPHABET: alphabet_in = csr_pwdata[0];
            scp_pkg::REG_COMPACT:  compact_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         scp_pkg::REG_ALPHABET: csr_prdata = {31'd0, alphabet_ff};
         scp_pkg::REG_COMPACT:  csr_prdata = {31'd0, compact_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------- packing stage
   logic                          req_accept;
   logic                          take_code;
   logic [3:0]                    width;
   logic [SB-1:0]                 capacity;
   logic [scp_pkg::CODE_BITS-1:0] code;
   logic [WB-1:0]                 acc_shift;
   logic [SB-1:0]                 slot_step;
   logic [LENGTH_BITS-1:0]        length_step;
   logic                          word_full;
   logic                          flush;
   logic [SB-1:0]                 remaining;
   logic [5:0]                    pad_shift;
   logic [WB-1:0]                 word_out;
   logic                          result_valid;
   logic                          push;
   scp_pkg::rsp_payload_type      result;
   logic [scp_pkg::SEQ_LEN_BITS-1:0] length_out;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign take_code  = req_data.char_in != scp_pkg::CHAR_NEWLINE;

   assign width    = scp_pkg::slot_width(alphabet_ff, compact_ff);
   assign capacity = scp_pkg::slot_capacity(alphabet_ff, compact_ff);
   assign code     = scp_pkg::map_code(req_data.char_in, alphabet_ff);

   always_comb begin
      acc_shift   = acc_ff;
      slot_step   = slot_count_ff;
      length_step = length_counter_ff;
      if (take_code) begin
         acc_shift = (acc_ff << width) | {{(WB-scp_pkg::CODE_BITS){1'b0}}, code};
         if (slot_count_ff != '1) begin
            slot_step = slot_count_ff + 1'b1;
         end
         if (length_counter_ff != '1) begin
            length_step = length_counter_ff + 1'b1;
         end
      end
   end

   assign word_full = take_code && (slot_step >= capacity);
   assign flush     = req_data.end_of_sequence && !word_full && (slot_step != '0);
   assign remaining = (slot_step >= capacity) ? '0 : capacity - slot_step;
   // padding stays below 32 bits since at least one slot is in use
   assign pad_shift = 6'(remaining) * 6'(width);

   always_comb begin
      word_out = '0;
      if (word_full) begin
         word_out = acc_shift;
      end else if (flush) begin
         word_out = acc_shift << pad_shift;
      end
   end

   generate
      if (LENGTH_BITS > scp_pkg::SEQ_LEN_BITS) begin : g_len_sat
         assign length_out = (|length_step[LENGTH_BITS-1:scp_pkg::SEQ_LEN_BITS]) ?
                             '1 : length_step[scp_pkg::SEQ_LEN_BITS-1:0];
      end else begin : g_len_ext
         assign length_out = scp_pkg::SEQ_LEN_BITS'(length_step);
      end
   endgenerate

   assign result_valid = word_full || req_data.end_of_sequence;
   assign push         = req_accept && result_valid;

   always_comb begin
      result.packed_word = word_out;
      result.word_valid  = word_full || flush;
      result.last_word   = req_data.end_of_sequence;
      result.seq_length  = length_out;
   end

   always_comb begin
      acc_in            = acc_ff;
      slot_count_in     = slot_count_ff;
      length_counter_in = length_counter_ff;
      if (req_accept) begin
         if (req_data.end_of_sequence) begin
            acc_in            = scp_pkg::SENTINEL_WORD;
            slot_count_in     = '0;
            length_counter_in = '0;
         end else if (word_full) begin
            acc_in            = scp_pkg::SENTINEL_WORD;
            slot_count_in     = '0;
            length_counter_in = length_step;
         end else begin
            acc_in            = acc_shift;
            slot_count_in     = slot_step;
            length_counter_in = length_step;
         end
      end
   end

   // ---------------- result register and skid entry
   logic out_take;

   assign out_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff       <= 1'b0;
         compact_ff        <= 1'b0;
         acc_ff            <= scp_pkg::SENTINEL_WORD;
         slot_count_ff     <= '0;
         length_counter_ff <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         alphabet_ff       <= alphabet_in;
         compact_ff        <= compact_in;
         acc_ff            <= acc_in;
         slot_count_ff     <= slot_count_in;
         length_counter_ff <= length_counter_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid_ff && !skid_valid_ff, "result entries not empty after reset")
   `ASSERT_CLK(a_skid_behind_out, clock, reset, !skid_valid_ff || rsp_valid_ff, "skid entry holds a result while the output register is empty")
   `ASSERT_CLK(a_end_clears_state, clock, reset, req_accept && req_data.end_of_sequence |=> slot_count_ff == '0 && length_counter_ff == '0 && acc_ff == scp_pkg::SENTINEL_WORD, "sequence state not cleared after end of sequence")
   `ASSERT_CLK(a_empty_result_is_last, clock, reset, rsp_valid && !rsp_data.word_valid |-> rsp_data.last_word, "result without a word does not end the sequence")

endmodule
